>>> rtl/prd_pkg.sv
// Shared types, constants and pointer helpers for the packed ring deque.
// Used by prd_ctrl and packed_ring_deque_core; depends on nothing else.
`timescale 1ns / 1ps

package prd_pkg;

   localparam int ELEM_BITS = 3;
   localparam int MAX_SLOTS = 64;
   localparam int PTR_BITS  = $clog2(MAX_SLOTS);
   localparam int CNT_BITS  = $clog2(MAX_SLOTS + 1);

   localparam logic [CNT_BITS-1:0] CAP_MAX   = CNT_BITS'(MAX_SLOTS);
   localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(MAX_SLOTS);

   localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
   localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_BACK   = 2'd3;

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef struct packed {
      logic [1:0] operation;
      elem_type   value;
   } req_type;

   typedef struct packed {
      elem_type popped;
      logic     rejected;
      cnt_type  count;
      logic     is_full;
      logic     is_empty;
      elem_type front_value;
      elem_type back_value;
   } rsp_type;

   // What the lookup stage needs to finish one word once the store has answered.
   typedef struct packed {
      logic     take_front;
      logic     take_back;
      logic     rejected;
      cnt_type  fill;
      logic     full;
      logic     empty;
      logic     front_byp;
      logic     back_byp;
      elem_type byp_data;
   } stage_type;

   typedef struct packed {
      logic     wr_en;
      ptr_type  wr_addr;
      elem_type wr_data;
      logic     rd_en;
      ptr_type  rd_addr_front;
      ptr_type  rd_addr_back;
   } ram_req_type;

   function automatic ptr_type step_fwd(ptr_type p, cnt_type cap);
      cnt_type nxt;
      nxt = {1'b0, p} + cnt_type'(1);
      return (nxt >= cap) ? '0 : nxt[PTR_BITS-1:0];
   endfunction

   // A pointer at or beyond the capacity steps back onto the last slot in use.
   function automatic ptr_type step_back(ptr_type p, cnt_type cap);
      cnt_type last;
      last = cap - cnt_type'(1);
      return (p == '0 || {1'b0, p} >= cap) ? last[PTR_BITS-1:0] : p - ptr_type'(1);
   endfunction

endpackage

>>> rtl/packed_ring_deque_core.sv
// Packed ring deque: an accepted word passes through the ring store's registered read and
// the lookup stage register, then the result register. Throughput is one word per cycle
// when the output is not stalled, set by the store's single write port and two read ports.
// Reset is synchronous and active high: it clears the pointers, the fill count, the
// pipeline valids and sets capacity to 64. The ring store itself is not cleared.
// Uses prd_pkg, prd_ctrl and prd_ram.
`timescale 1ns / 1ps

module packed_ring_deque_core
   import prd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  cnt_type csr_data
);

   cnt_type     capacity_ff;
   stage_type   info;
   ram_req_type ram_req;
   stage_type   stage_ff;
   logic        stage_valid_ff, stage_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   elem_type    last_front_ff;
   elem_type    last_back_ff;
   elem_type    rd_front;
   elem_type    rd_back;
   elem_type    front_val;
   elem_type    back_val;
   logic        out_free;
   logic        stage_adv;
   logic        accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stage_adv = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   prd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .capacity (capacity_ff),
      .info     (info),
      .ram_req  (ram_req)
   );

   prd_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_req.wr_en),
      .wr_addr   (ram_req.wr_addr),
      .wr_data   (ram_req.wr_data),
      .rd_en     (ram_req.rd_en),
      .rd_addr_a (ram_req.rd_addr_front),
      .rd_addr_b (ram_req.rd_addr_back),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_adv) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? stage_valid_ff : rsp_valid_ff;
   end

   // A popped element is the front or back left by the word before this one.
   always_comb begin
      front_val = stage_ff.front_byp ? stage_ff.byp_data : rd_front;
      back_val  = stage_ff.back_byp ? stage_ff.byp_data : rd_back;
      if (stage_ff.empty) begin
         front_val = '0;
         back_val  = '0;
      end
      rsp_in.popped = '0;
      if (stage_ff.take_front) begin
         rsp_in.popped = last_front_ff;
      end else if (stage_ff.take_back) begin
         rsp_in.popped = last_back_ff;
      end
      rsp_in.rejected    = stage_ff.rejected;
      rsp_in.count       = stage_ff.fill;
      rsp_in.is_full     = stage_ff.full;
      rsp_in.is_empty    = stage_ff.empty;
      rsp_in.front_value = front_val;
      rsp_in.back_value  = back_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= info;
      end
      if (stage_adv) begin
         rsp_ff        <= rsp_in;
         last_front_ff <= front_val;
         last_back_ff  <= back_val;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid_ff)
      else $error("accepted word did not reach the lookup stage");

   a_read_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_adv) |=> ($stable(rd_front) && $stable(rd_back)))
      else $error("store read data changed while the lookup stage was held");

   a_stage_to_output: assert property (@(posedge clock) disable iff (reset)
      stage_adv |=> rsp_valid_ff)
      else $error("advancing word did not reach the result register");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.count == '0)))
      else $error("empty flag disagrees with the count");
`endif

endmodule

>>> rtl/prd_ram.sv
// Generic simple RAM: one write port and two registered read ports.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module prd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

>>> rtl/prd_ctrl.sv
// Pointer and fill-level control of the ring deque: decides each operation,
// drives the ring store's ports and passes the outcome on. Uses prd_pkg.
`timescale 1ns / 1ps

module prd_ctrl
   import prd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  cnt_type     capacity,
   output stage_type   info,
   output ram_req_type ram_req
);

   ptr_type  head_ff, head_in;
   ptr_type  tail_ff, tail_in;
   cnt_type  fill_ff, fill_in;
   cnt_type  cap_eff;
   logic     rejected;
   logic     wr_en;
   ptr_type  wr_addr;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = cnt_type'(1);
      end else if (capacity > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = capacity;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      rejected = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      case (req.operation)
         OP_PUSH_BACK: begin
            if (fill_ff >= cap_eff) begin
               rejected = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (fill_ff == '0) begin
                  head_in = tail_ff;
               end else begin
                  tail_in = step_fwd(tail_ff, cap_eff);
               end
               wr_addr = tail_in;
               fill_in = fill_ff + cnt_type'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (fill_ff >= cap_eff) begin
               rejected = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (fill_ff == '0) begin
                  tail_in = head_ff;
               end else begin
                  head_in = step_back(head_ff, cap_eff);
               end
               wr_addr = head_in;
               fill_in = fill_ff + cnt_type'(1);
            end
         end
         OP_POP_FRONT: begin
            if (fill_ff == '0) begin
               rejected = 1'b1;
            end else begin
               head_in = step_fwd(head_ff, cap_eff);
               fill_in = fill_ff - cnt_type'(1);
            end
         end
         OP_POP_BACK: begin
            if (fill_ff == '0) begin
               rejected = 1'b1;
            end else begin
               tail_in = step_back(tail_ff, cap_eff);
               fill_in = fill_ff - cnt_type'(1);
            end
         end
         default: begin
            rejected = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // The store returns old data on a same-cycle write, so a freshly written
   // front or back slot is forwarded from the write data instead.
   always_comb begin
      info.take_front = (req.operation == OP_POP_FRONT) && !rejected;
      info.take_back  = (req.operation == OP_POP_BACK) && !rejected;
      info.rejected   = rejected;
      info.fill       = fill_in;
      info.full       = fill_in >= cap_eff;
      info.empty      = fill_in == '0;
      info.front_byp  = wr_en && (wr_addr == head_in);
      info.back_byp   = wr_en && (wr_addr == tail_in);
      info.byp_data   = req.value;

      ram_req.wr_en         = wr_en && accept;
      ram_req.wr_addr       = wr_addr;
      ram_req.wr_data       = req.value;
      ram_req.rd_en         = accept;
      ram_req.rd_addr_front = head_in;
      ram_req.rd_addr_back  = tail_in;
   end

endmodule

>>> tb/sv/packed_ring_deque_core_tb.sv
// Self-checking testbench for packed_ring_deque_core: directed and random deque words,
// checked against a scoreboard that tracks the ring contents, pointers and capacity.
// Depends on prd_pkg and the packed_ring_deque_core RTL only.
`timescale 1ns / 1ps

module packed_ring_deque_core_tb
   import prd_pkg::*;
();

   class deque_scoreboard;
      elem_type ring[MAX_SLOTS];
      bit       stored[MAX_SLOTS];
      int       front_idx;
      int       back_idx;
      int       held;
      int       cap_setting;
      bit       stray_read;
      rsp_type  pending_q[$];
      int       failures;

      function new();
         front_idx   = 0;
         back_idx    = 0;
         held        = 0;
         cap_setting = MAX_SLOTS;
         failures    = 0;
      endfunction

      function int slots_in_use();
         if (cap_setting == 0) return 1;
         if (cap_setting > MAX_SLOTS) return MAX_SLOTS;
         return cap_setting;
      endfunction

      function int wrap_up(int p, int lim);
         return (p + 1 >= lim) ? 0 : p + 1;
      endfunction

      // A pointer left beyond a shrunken ring steps back onto its last slot.
      function int wrap_down(int p, int lim);
         return (p == 0 || p >= lim) ? lim - 1 : p - 1;
      endfunction

      function elem_type fetch(int p);
         if (!stored[p]) stray_read = 1'b1;
         return ring[p];
      endfunction

      function rsp_type deque_step(logic [1:0] op, elem_type v);
         rsp_type r;
         int      lim;
         int      slot;
         r   = '0;
         lim = slots_in_use();
         if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            if (held >= lim) begin
               r.rejected = 1'b1;
            end else begin
               if (held == 0) begin
                  if (op == OP_PUSH_BACK) front_idx = back_idx;
                  else back_idx = front_idx;
               end else if (op == OP_PUSH_BACK) begin
                  back_idx = wrap_up(back_idx, lim);
               end else begin
                  front_idx = wrap_down(front_idx, lim);
               end
               slot         = (op == OP_PUSH_BACK) ? back_idx : front_idx;
               ring[slot]   = v;
               stored[slot] = 1'b1;
               held++;
            end
         end else if (held == 0) begin
            r.rejected = 1'b1;
         end else if (op == OP_POP_FRONT) begin
            r.popped  = fetch(front_idx);
            front_idx = wrap_up(front_idx, lim);
            held--;
         end else begin
            r.popped = fetch(back_idx);
            back_idx = wrap_down(back_idx, lim);
            held--;
         end
         r.count    = cnt_type'(held);
         r.is_full  = (held >= lim);
         r.is_empty = (held == 0);
         if (held != 0) begin
            r.front_value = fetch(front_idx);
            r.back_value  = fetch(back_idx);
         end
         return r;
      endfunction

      // Tries a word on a copy of the state: false if it would read a never-written slot.
      function bit is_safe(logic [1:0] op, elem_type v);
         elem_type saved_ring[MAX_SLOTS];
         bit       saved_stored[MAX_SLOTS];
         int       saved_front;
         int       saved_back;
         int       saved_held;
         saved_ring   = ring;
         saved_stored = stored;
         saved_front  = front_idx;
         saved_back   = back_idx;
         saved_held   = held;
         stray_read   = 1'b0;
         void'(deque_step(op, v));
         ring      = saved_ring;
         stored    = saved_stored;
         front_idx = saved_front;
         back_idx  = saved_back;
         held      = saved_held;
         return !stray_read;
      endfunction

      function void note_request(req_type r);
         pending_q.insert(pending_q.size(), deque_step(r.operation, r.value));
      endfunction

      function void field_check(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            $error("result word with no word outstanding: %p", got);
            failures++;
            return;
         end
         want = pending_q[0];
         pending_q.delete(0);
         field_check("popped", int'(want.popped), int'(got.popped));
         field_check("rejected", int'(want.rejected), int'(got.rejected));
         field_check("count", int'(want.count), int'(got.count));
         field_check("is_full", int'(want.is_full), int'(got.is_full));
         field_check("is_empty", int'(want.is_empty), int'(got.is_empty));
         field_check("front_value", int'(want.front_value), int'(got.front_value));
         field_check("back_value", int'(want.back_value), int'(got.back_value));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   cnt_type csr_data;

   deque_scoreboard board = new();
   bit long_hold = 1'b0;

   packed_ring_deque_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Offers one word and returns at the edge that takes it; valid stays up when keep is set.
   task automatic send(input logic [1:0] op, input elem_type v, input bit keep);
      req_type r;
      r.operation = op;
      r.value     = v;
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(r);
      if (!keep) req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int cap);
      drain();
      repeat (4) @(posedge clock);
      csr_data  <= cnt_type'(cap);
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.cap_setting = cap;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_result(rsp_payload);
   end

   // Receiver: segments of no stall, random stall and periodic stall, plus one long hold.
   initial begin : rsp_side
      int seg;
      int mode;
      int period;
      int k;
      forever begin
         if (long_hold) begin
            for (k = 0; k < 400; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            long_hold = 1'b0;
         end
         seg    = $urandom_range(8, 64);
         mode   = $urandom_range(0, 2);
         period = $urandom_range(2, 5);
         for (k = 0; k < seg; k++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= (k % period == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int         caps[12];
      int         per_phase;
      int         burst_left;
      int         gap_after;
      int         n;
      int         ph;
      bit         filling;
      bit         last;
      logic [1:0] op;
      elem_type   v;

      caps        = '{64, 1, 0, 2, 127, 5, 33, 3, 100, 64, 13, 64};
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset capacity: pops on empty, a push front into an empty ring, a push back, then pops.
      send(OP_POP_FRONT, 3'd5, 1'b1);
      send(OP_POP_BACK, 3'd2, 1'b1);
      send(OP_PUSH_FRONT, 3'd7, 1'b1);
      send(OP_PUSH_BACK, 3'd0, 1'b1);
      send(OP_POP_BACK, 3'd0, 1'b1);
      send(OP_POP_FRONT, 3'd0, 1'b0);

      // Two slots: fill, refused pushes on full, wrap in both directions, refused pop.
      write_capacity(2);
      send(OP_PUSH_BACK, 3'd5, 1'b1);
      send(OP_PUSH_FRONT, 3'd2, 1'b1);
      send(OP_PUSH_BACK, 3'd1, 1'b1);
      send(OP_PUSH_FRONT, 3'd6, 1'b1);
      send(OP_POP_FRONT, 3'd3, 1'b1);
      send(OP_POP_BACK, 3'd4, 1'b1);
      send(OP_POP_BACK, 3'd7, 1'b1);
      send(OP_PUSH_FRONT, 3'd3, 1'b1);
      send(OP_POP_BACK, 3'd0, 1'b1);
      send(OP_PUSH_BACK, 3'd4, 1'b1);
      send(OP_PUSH_BACK, 3'd7, 1'b0);

      // Shrink to one slot while two elements are held.
      write_capacity(1);
      send(OP_PUSH_BACK, 3'd6, 1'b1);
      send(OP_POP_FRONT, 3'd1, 1'b1);
      send(OP_POP_FRONT, 3'd2, 1'b1);
      send(OP_PUSH_BACK, 3'd6, 1'b1);
      send(OP_PUSH_FRONT, 3'd1, 1'b1);
      send(OP_POP_BACK, 3'd5, 1'b0);

      per_phase  = 146;
      filling    = 1'b1;
      burst_left = 0;
      gap_after  = 0;
      for (ph = 0; ph < 12; ph++) begin
         write_capacity(caps[ph]);
         if (ph == 6) long_hold = 1'b1;
         for (n = 0; n < per_phase; n++) begin
            last = (n == per_phase - 1);
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_after  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst_left--;

            // Mostly fill-then-drain sweeps so the ring wraps and hits full and empty.
            v = elem_type'($urandom_range(0, 7));
            if (board.held >= board.slots_in_use()) filling = 1'b0;
            else if (board.held == 0) filling = 1'b1;
            else if ($urandom_range(0, 39) == 0) filling = !filling;
            if ($urandom_range(0, 9) == 0)
               op = 2'($urandom_range(0, 3));
            else if (($urandom_range(0, 99) < 80) == filling)
               op = ($urandom_range(0, 1) == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
               op = ($urandom_range(0, 1) == 1) ? OP_POP_FRONT : OP_POP_BACK;
            if (!board.is_safe(op, v)) op = OP_PUSH_BACK;

            send(op, v, !(last || (burst_left == 0 && gap_after > 0)));
            if (!last && burst_left == 0 && gap_after > 0) begin
               if ($urandom_range(0, 29) == 0) drain();
               repeat (gap_after) @(posedge clock);
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/prd_pkg.sv
rtl/prd_ram.sv
rtl/prd_ctrl.sv
rtl/packed_ring_deque_core.sv
tb/sv/packed_ring_deque_core_tb.sv
